// ----- rtl/core/kls_pkg.sv -----
// shared types and constants for the keyframe lerp sampler
// no dependencies; compiled first
package kls_pkg;

    localparam int KLS_MAX_KEYS   = 64;
    localparam int KLS_TIME_W     = 32;
    localparam int KLS_VAL_W      = 32;
    localparam int KLS_IDX_W      = 6;
    localparam int KLS_CNT_W      = 7;
    localparam int KLS_COMP       = 4;
    localparam int KLS_FRAC_W     = 16;
    localparam int KLS_CFG_IDX_W  = 1;
    localparam int KLS_CFG_DATA_W = 7;

    // configuration register indexes
    localparam logic [KLS_CFG_IDX_W-1:0] KLS_REG_KEY_COUNT = 1'b0;
    localparam logic [KLS_CFG_IDX_W-1:0] KLS_REG_FOUR_COMP = 1'b1;

    // input item function codes
    localparam logic KLS_FUNC_LOAD   = 1'b0;
    localparam logic KLS_FUNC_SAMPLE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_VLO,
        S_VHI,
        S_VCAP,
        S_BLEND,
        S_OUT,
        S_EMPTY
    } t_kls_state;

    typedef struct packed {
        logic in_rdy;
        logic scan;
        logic div_step;
        logic val_rd_hi;
        logic val_cap;
        logic blend;
        logic out_load;
        logic out_empty;
    } t_kls_cmd;

    typedef struct packed {
        logic smp_acc;
        logic n_zero;
        logic scan_hit;
        logic scan_last;
        logic interp;
        logic div_done;
        logic blend_done;
        logic out_free;
    } t_kls_stat;

endpackage

// ----- rtl/core/kls_in_if.sv -----
// input channel of the keyframe lerp sampler: valid/ready plus item payload
// depends on kls_pkg
interface kls_in_if;
    import kls_pkg::*;

    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [KLS_IDX_W-1:0]         key_index;
    logic [KLS_TIME_W-1:0]        key_time;
    logic signed [KLS_VAL_W-1:0]  val_x;
    logic signed [KLS_VAL_W-1:0]  val_y;
    logic signed [KLS_VAL_W-1:0]  val_z;
    logic signed [KLS_VAL_W-1:0]  val_w;
    logic [KLS_TIME_W-1:0]        query_time;

    modport source (
        output valid, func, key_index, key_time, val_x, val_y, val_z, val_w, query_time,
        input  ready
    );

    modport sink (
        input  valid, func, key_index, key_time, val_x, val_y, val_z, val_w, query_time,
        output ready
    );
endinterface

// ----- rtl/core/kls_out_if.sv -----
// result channel of the keyframe lerp sampler: valid/ready plus result payload
// depends on kls_pkg
interface kls_out_if;
    import kls_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [KLS_VAL_W-1:0]  out_x;
    logic signed [KLS_VAL_W-1:0]  out_y;
    logic signed [KLS_VAL_W-1:0]  out_z;
    logic signed [KLS_VAL_W-1:0]  out_w;
    logic                         empty_res;

    modport source (
        output valid, out_x, out_y, out_z, out_w, empty_res,
        input  ready
    );

    modport sink (
        input  valid, out_x, out_y, out_z, out_w, empty_res,
        output ready
    );
endinterface

// ----- rtl/core/kls_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
module kls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/core/kls_ctrl.sv -----
// sequencing state machine of the keyframe lerp sampler
// depends on kls_pkg; drives the datapath kls_dp by command struct
module kls_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kls_pkg::t_kls_stat  i_stat,
    output kls_pkg::t_kls_cmd   o_cmd
);
    import kls_pkg::*;

    t_kls_state r_state;
    t_kls_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_stat.smp_acc) begin
                    n_state = i_stat.n_zero ? S_EMPTY : S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_hit) begin
                    n_state = i_stat.interp ? S_DIV : S_VLO;
                end else if (i_stat.scan_last) begin
                    n_state = S_VLO;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_VLO;
                end
            end
            S_VLO:   n_state = S_VHI;
            S_VHI:   n_state = S_VCAP;
            S_VCAP:  n_state = S_BLEND;
            S_BLEND: begin
                if (i_stat.blend_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT, S_EMPTY: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE:  o_cmd.in_rdy    = 1'b1;
            S_SCAN:  o_cmd.scan      = 1'b1;
            S_DIV:   o_cmd.div_step  = 1'b1;
            S_VLO:   o_cmd           = '0;
            S_VHI:   o_cmd.val_rd_hi = 1'b1;
            S_VCAP:  o_cmd.val_cap   = 1'b1;
            S_BLEND: o_cmd.blend     = 1'b1;
            S_OUT:   o_cmd.out_load  = i_stat.out_free;
            S_EMPTY: o_cmd.out_empty = i_stat.out_free;
            default: o_cmd           = '0;
        endcase
    end

    // a result is only written into a free output register
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.out_load || o_cmd.out_empty) |-> i_stat.out_free)
        else $error("result loaded while output register occupied");

    // the datapath units are never driven together
    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.in_rdy, o_cmd.scan, o_cmd.div_step, o_cmd.blend,
                  o_cmd.out_load, o_cmd.out_empty}))
        else $error("more than one datapath unit commanded");

    // a sample on an empty table goes straight to the empty result
    a_empty_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_stat.smp_acc && i_stat.n_zero) |=> r_state == S_EMPTY)
        else $error("empty table sample took the scan path");
endmodule

// ----- rtl/core/kls_dp.sv -----
// datapath of the keyframe lerp sampler: key tables, scan, divider, blend, output
// depends on kls_pkg, kls_in_if, kls_out_if, kls_ram
module kls_dp #(
    parameter int MAX_KEYS = kls_pkg::KLS_MAX_KEYS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [kls_pkg::KLS_CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [kls_pkg::KLS_CFG_DATA_W-1:0]  i_cfg_data,
    input  kls_pkg::t_kls_cmd                   i_cmd,
    output kls_pkg::t_kls_stat                  o_stat,
    kls_in_if.sink                              i_in,
    kls_out_if.source                           o_out
);
    import kls_pkg::*;

    localparam int AW     = $clog2(MAX_KEYS);
    localparam int NW     = $clog2(MAX_KEYS + 1);
    localparam int CW     = AW + 1;
    localparam int DCW    = $clog2(KLS_FRAC_W);
    localparam int BCW    = $clog2(KLS_COMP + 1);
    localparam int VW     = KLS_COMP * KLS_VAL_W;
    localparam int PW     = KLS_VAL_W + 1 + KLS_FRAC_W + 1;
    localparam logic [DCW-1:0] DIV_LAST   = DCW'(KLS_FRAC_W - 1);
    localparam logic [BCW-1:0] BLEND_LAST = BCW'(KLS_COMP);

    // configuration
    logic [KLS_CNT_W-1:0]  r_key_count;
    logic                  r_four;

    // scan
    logic [KLS_TIME_W-1:0] r_q;
    logic [NW-1:0]         r_n;
    logic [AW-1:0]         r_cmp_idx;
    logic [KLS_TIME_W-1:0] r_prev_t;
    logic [AW-1:0]         r_lo;
    logic [AW-1:0]         r_hi;

    // divider
    logic [KLS_TIME_W-1:0] r_rem;
    logic [KLS_TIME_W-1:0] r_den;
    logic [KLS_FRAC_W-1:0] r_alpha;
    logic [DCW-1:0]        r_div_cnt;

    // blend
    logic [VW-1:0]         r_v_lo;
    logic [VW-1:0]         r_v_hi;
    logic [BCW-1:0]        r_bk;
    logic [KLS_VAL_W-1:0]  r_base;
    logic [KLS_VAL_W-1:0]  r_prod_q;
    logic [1:0]            r_pidx;
    logic [KLS_VAL_W-1:0]  r_res [KLS_COMP];

    // output register
    logic                  r_out_vld;
    logic [KLS_VAL_W-1:0]  r_ox;
    logic [KLS_VAL_W-1:0]  r_oy;
    logic [KLS_VAL_W-1:0]  r_oz;
    logic [KLS_VAL_W-1:0]  r_ow;
    logic                  r_oempty;

    logic                  w_in_acc;
    logic                  w_load_we;
    logic [AW-1:0]         w_waddr;
    logic [AW-1:0]         w_t_raddr;
    logic [AW-1:0]         w_v_raddr;
    logic [KLS_TIME_W-1:0] w_rd_t;
    logic [VW-1:0]         w_rd_v;
    logic [31:0]           w_n_sat;
    logic [AW-1:0]         w_last_idx;
    logic                  w_hit;
    logic                  w_last;
    logic                  w_interp;
    logic [KLS_TIME_W:0]   w_rem2;
    logic                  w_ge;
    logic [1:0]            w_k;
    logic [KLS_VAL_W-1:0]  w_vlo_c;
    logic [KLS_VAL_W-1:0]  w_vhi_c;
    logic signed [KLS_VAL_W:0] w_diff;
    logic signed [PW-1:0]  w_prod;
    logic                  w_out_free;

    assign i_in.ready = i_cmd.in_rdy;
    assign w_in_acc   = i_in.valid && i_cmd.in_rdy;
    assign w_load_we  = w_in_acc && (i_in.func == KLS_FUNC_LOAD)
                        && (32'(i_in.key_index) < 32'(MAX_KEYS));
    assign w_waddr    = AW'(i_in.key_index);

    assign w_t_raddr  = i_cmd.scan ? AW'(r_cmp_idx + 1'b1) : '0;
    assign w_v_raddr  = i_cmd.val_rd_hi ? r_hi : r_lo;

    kls_ram #(.WIDTH(KLS_TIME_W), .DEPTH(MAX_KEYS)) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (w_load_we),
        .i_waddr (w_waddr),
        .i_wdata (i_in.key_time),
        .i_raddr (w_t_raddr),
        .o_rdata (w_rd_t)
    );

    kls_ram #(.WIDTH(VW), .DEPTH(MAX_KEYS)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (w_load_we),
        .i_waddr (w_waddr),
        .i_wdata ({i_in.val_w, i_in.val_z, i_in.val_y, i_in.val_x}),
        .i_raddr (w_v_raddr),
        .o_rdata (w_rd_v)
    );

    // saturate the count to the table depth
    assign w_n_sat    = (32'(r_key_count) > 32'(MAX_KEYS)) ? 32'(MAX_KEYS)
                                                           : 32'(r_key_count);
    assign w_last_idx = AW'(r_n - 1'b1);

    assign w_hit    = r_q < w_rd_t;
    assign w_last   = (CW'(r_cmp_idx) + CW'(1)) == CW'(r_n);
    assign w_interp = w_hit && (r_cmp_idx != '0);

    // restoring division step, remainder stays below the divisor
    assign w_rem2 = {r_rem, 1'b0};
    assign w_ge   = w_rem2 >= {1'b0, r_den};

    assign w_k     = r_bk[1:0];
    assign w_vlo_c = r_v_lo[KLS_VAL_W*w_k +: KLS_VAL_W];
    assign w_vhi_c = r_v_hi[KLS_VAL_W*w_k +: KLS_VAL_W];
    assign w_diff  = $signed({w_vhi_c[KLS_VAL_W-1], w_vhi_c})
                   - $signed({w_vlo_c[KLS_VAL_W-1], w_vlo_c});
    assign w_prod  = PW'(w_diff) * PW'($signed({1'b0, r_alpha}));

    assign w_out_free = !r_out_vld || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= '0;
            r_four      <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    KLS_REG_KEY_COUNT: r_key_count <= i_cfg_data[KLS_CNT_W-1:0];
                    KLS_REG_FOUR_COMP: r_four      <= i_cfg_data[0];
                    default:           r_four      <= r_four;
                endcase
            end
            if (i_cmd.out_load || i_cmd.out_empty) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_in.func == KLS_FUNC_SAMPLE) begin
            r_q       <= i_in.query_time;
            r_n       <= NW'(w_n_sat);
            r_cmp_idx <= '0;
        end

        if (i_cmd.scan) begin
            r_cmp_idx <= AW'(r_cmp_idx + 1'b1);
            r_prev_t  <= w_rd_t;
            r_div_cnt <= '0;
            if (w_interp) begin
                r_lo    <= AW'(r_cmp_idx - 1'b1);
                r_hi    <= r_cmp_idx;
                r_rem   <= r_q - r_prev_t;
                r_den   <= w_rd_t - r_prev_t;
                r_alpha <= '0;
            end else if (w_hit || w_last) begin
                r_lo    <= w_last_idx;
                r_hi    <= w_last_idx;
                r_alpha <= '0;
            end
        end

        if (i_cmd.div_step) begin
            r_rem     <= w_ge ? KLS_TIME_W'(w_rem2 - {1'b0, r_den}) : w_rem2[KLS_TIME_W-1:0];
            r_alpha   <= {r_alpha[KLS_FRAC_W-2:0], w_ge};
            r_div_cnt <= DCW'(r_div_cnt + 1'b1);
        end

        if (i_cmd.val_rd_hi) begin
            r_v_lo <= w_rd_v;
        end
        if (i_cmd.val_cap) begin
            r_v_hi <= w_rd_v;
            r_bk   <= '0;
        end

        // two stage blend: multiply component k while adding component k-1
        if (i_cmd.blend) begin
            r_bk <= BCW'(r_bk + 1'b1);
            if (r_bk != BLEND_LAST) begin
                r_prod_q <= w_prod[KLS_FRAC_W +: KLS_VAL_W];
                r_base   <= w_vlo_c;
                r_pidx   <= w_k;
            end
            if (r_bk != '0) begin
                r_res[r_pidx] <= r_base + r_prod_q;
            end
        end

        if (i_cmd.out_load) begin
            r_ox     <= r_res[0];
            r_oy     <= r_res[1];
            r_oz     <= r_res[2];
            r_ow     <= r_four ? r_res[3] : '0;
            r_oempty <= 1'b0;
        end else if (i_cmd.out_empty) begin
            r_ox     <= '0;
            r_oy     <= '0;
            r_oz     <= '0;
            r_ow     <= '0;
            r_oempty <= 1'b1;
        end
    end

    assign o_out.valid     = r_out_vld;
    assign o_out.out_x     = r_ox;
    assign o_out.out_y     = r_oy;
    assign o_out.out_z     = r_oz;
    assign o_out.out_w     = r_ow;
    assign o_out.empty_res = r_oempty;

    always_comb begin
        o_stat            = '0;
        o_stat.smp_acc    = w_in_acc && (i_in.func == KLS_FUNC_SAMPLE);
        o_stat.n_zero     = r_key_count == '0;
        o_stat.scan_hit   = w_hit;
        o_stat.scan_last  = w_last;
        o_stat.interp     = w_interp;
        o_stat.div_done   = r_div_cnt == DIV_LAST;
        o_stat.blend_done = r_bk == BLEND_LAST;
        o_stat.out_free   = w_out_free;
    end

    // divider remainder must stay below a nonzero divisor
    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_den != '0 && r_rem < r_den))
        else $error("divider remainder out of range");

    // a loaded result shows up on the output channel next cycle
    a_out_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load || i_cmd.out_empty) |=> o_out.valid)
        else $error("loaded result not presented");

    // tables are only written by a load transaction while idle
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_we |-> (i_cmd.in_rdy && !i_cmd.scan && !i_cmd.blend))
        else $error("table written outside idle");
endmodule

// ----- rtl/core/keyframe_lerp_sampler.sv -----
// load transaction: accepted while idle, writes one table entry, no result
// sample transaction: scans the time table up to the first key later than the query (all n keys
// on a miss), then runs the divider when interpolating, fetches the two value entries, blends the
// components and loads the output register; an empty table goes straight to the empty result
// one sample in flight; scan is set by the time memory's single read port
// reset clears controller state, output valid, key count and mode; tables are not cleared
module keyframe_lerp_sampler #(
    parameter int MAX_KEYS = kls_pkg::KLS_MAX_KEYS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port, one register per write
    input  logic                                i_cfg_we,
    input  logic [kls_pkg::KLS_CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [kls_pkg::KLS_CFG_DATA_W-1:0]  i_cfg_data,
    // item and result channels
    kls_in_if.sink                              i_in,
    kls_out_if.source                           o_out
);
    import kls_pkg::*;

    // command and status between the sequencer and the datapath
    t_kls_cmd  w_cmd;
    t_kls_stat w_stat;

    // sequencer: idle, scan, optional divide, value fetch, blend, result hand-off; an empty table skips to the result
    kls_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // datapath: key tables in ram, scan compare, restoring divider for the
    // q0.16 fraction, shared multiplier for the four components, output register
    // so the next transaction can be taken while a result waits
    kls_dp #(.MAX_KEYS(MAX_KEYS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_in       (i_in),
        .o_out      (o_out)
    );
endmodule

// ----- bench/keyframe_lerp_sampler_tb.sv -----
// self-checking testbench for keyframe_lerp_sampler: directed and random load/sample traffic
// depends on kls_pkg, kls_in_if, kls_out_if and the keyframe_lerp_sampler rtl
module keyframe_lerp_sampler_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import kls_pkg::*;

    // total transactions queued before the run winds down
    localparam int ITEM_TARGET   = 1720;
    // random phases begun once this many transactions are queued drop all idling
    localparam int CALM_FROM     = 1450;
    // settle time after the queues drain, longer than a worst-case sample
    localparam int SETTLE_CYCLES = 120;
    // ~1700 transactions x (worst-case busy + longest source gap + longest sink stall), taken ~7x over
    localparam int CYCLE_LIMIT   = 1_500_000;

    typedef struct {
        logic                  func;
        logic [KLS_IDX_W-1:0]  key_index;
        logic [KLS_TIME_W-1:0] key_time;
        logic [KLS_VAL_W-1:0]  val[KLS_COMP];
        logic [KLS_TIME_W-1:0] query_time;
    } t_kf_item;

    typedef struct {
        logic [KLS_VAL_W-1:0] comp[KLS_COMP];
        logic                 empty;
    } t_kf_point;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [KLS_CFG_IDX_W-1:0]  i_cfg_idx;
    logic [KLS_CFG_DATA_W-1:0] i_cfg_data;

    kls_in_if  in_if ();
    kls_out_if out_if ();

    keyframe_lerp_sampler i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // transactions waiting to be driven, and interpolated points still owed by the block
    t_kf_item  pending[$];
    t_kf_point due_points[$];

    // predictor copy of the keyframe table and the registers
    logic [KLS_TIME_W-1:0] trk_time[KLS_MAX_KEYS];
    logic [KLS_VAL_W-1:0]  trk_val[KLS_MAX_KEYS][KLS_COMP];
    logic [KLS_CNT_W-1:0]  trk_keys;
    logic                  trk_four;

    // keyframe times as the generator has queued them, used to aim queries
    logic [KLS_TIME_W-1:0] gen_time[KLS_MAX_KEYS];

    t_kf_item drv_item;
    logic     drv_busy;
    int       src_gap;
    int       snk_stall;
    bit       idle_on;
    int       queued;
    int       err_cnt;
    int       result_cnt;
    int       cycle_cnt;

    string comp_tag[KLS_COMP] = '{"out_x", "out_y", "out_z", "out_w"};

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // watchdog: a hung handshake or a missing result ends here
    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic log_error(string msg);
        if (err_cnt < 40) begin
            $display("%0t ns  mismatch: %s", $time, msg);
        end
        err_cnt++;
    endtask

    // signed blend v1 + floor((v2 - v1) * frac / 2^16), exact in 64 bits
    function automatic logic [KLS_VAL_W-1:0] lerp_comp(logic [KLS_VAL_W-1:0] a,
                                                       logic [KLS_VAL_W-1:0] b,
                                                       logic [KLS_FRAC_W-1:0] frac);
        logic signed [63:0] diff;
        logic signed [63:0] prod;
        diff = $signed({{32{b[31]}}, b}) - $signed({{32{a[31]}}, a});
        prod = diff * $signed({48'd0, frac});
        // arithmetic shift gives rounding toward minus infinity
        return a + 32'(prod >>> KLS_FRAC_W);
    endfunction

    // scan the keys in use for the first one later than the query and blend
    function automatic t_kf_point interp_point(logic [KLS_TIME_W-1:0] q);
        t_kf_point pt;
        int n;
        int hit;
        int lo;
        int hi;
        logic [63:0] num;
        logic [63:0] den;
        logic [KLS_FRAC_W-1:0] frac;
        n = (trk_keys > KLS_MAX_KEYS) ? KLS_MAX_KEYS : int'(trk_keys);
        pt.empty = 1'b0;
        for (int c = 0; c < KLS_COMP; c++) pt.comp[c] = '0;
        if (n == 0) begin
            pt.empty = 1'b1;
            return pt;
        end
        hit = -1;
        for (int i = 0; i < n; i++) begin
            if (hit < 0 && q < trk_time[i]) hit = i;
        end
        if (hit > 0) begin
            lo   = hit - 1;
            hi   = hit;
            num  = {32'd0, q - trk_time[lo]} << KLS_FRAC_W;
            den  = {32'd0, trk_time[hi] - trk_time[lo]};
            frac = (den != 0) ? 16'(num / den) : '0;
        end else begin
            // before the first key, or no later key at all: hold the last key
            lo   = n - 1;
            hi   = n - 1;
            frac = '0;
        end
        for (int c = 0; c < KLS_COMP; c++) begin
            pt.comp[c] = lerp_comp(trk_val[lo][c], trk_val[hi][c], frac);
        end
        // three-component mode reads w as zero
        if (!trk_four) pt.comp[3] = '0;
        return pt;
    endfunction

    // applied to each accepted transaction in acceptance order
    task automatic track_item(t_kf_item it);
        if (it.func == KLS_FUNC_LOAD) begin
            trk_time[it.key_index] = it.key_time;
            for (int c = 0; c < KLS_COMP; c++) trk_val[it.key_index][c] = it.val[c];
        end else begin
            due_points = {due_points, interp_point(it.query_time)};
        end
    endtask

    function automatic logic [KLS_VAL_W-1:0] rand_comp();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'($urandom_range(0, 511)) - 32'd256;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_load(int idx, logic [KLS_TIME_W-1:0] t, logic [KLS_VAL_W-1:0] x,
                             logic [KLS_VAL_W-1:0] y, logic [KLS_VAL_W-1:0] z,
                             logic [KLS_VAL_W-1:0] w);
        t_kf_item it;
        it.func       = KLS_FUNC_LOAD;
        it.key_index  = idx[KLS_IDX_W-1:0];
        it.key_time   = t;
        it.val[0]     = x;
        it.val[1]     = y;
        it.val[2]     = z;
        it.val[3]     = w;
        it.query_time = $urandom;
        gen_time[idx] = t;
        pending = {pending, it};
        queued++;
    endtask

    // payload fields other than the query are junk on a sample
    task automatic push_query(logic [KLS_TIME_W-1:0] q);
        t_kf_item it;
        it.func       = KLS_FUNC_SAMPLE;
        it.key_index  = $urandom;
        it.key_time   = $urandom;
        for (int c = 0; c < KLS_COMP; c++) it.val[c] = $urandom;
        it.query_time = q;
        pending = {pending, it};
        queued++;
    endtask

    // well-formed table prefix: times rising, with repeats and tiny steps now and then
    task automatic push_sorted_keys(int n);
        logic [63:0] t;
        logic [63:0] span;
        t    = ($urandom_range(0, 3) == 0) ? 64'd0 : 64'($urandom_range(0, 32'h7FFF_FFFF));
        span = (64'hFFFF_FFFF - t) / n;
        for (int i = 0; i < n; i++) begin
            push_load(i, 32'(t), rand_comp(), rand_comp(), rand_comp(), rand_comp());
            case ($urandom_range(0, 9))
                0:       t = t;
                1, 2:    t = t + $urandom_range(1, 255);
                default: t = t + ({32'd0, $urandom} % (span + 1));
            endcase
        end
    endtask

    // rewrite one entry with a time kept between its neighbours when they are in order
    task automatic push_repair_load();
        int i;
        logic [63:0] lo_t;
        logic [63:0] hi_t;
        i    = $urandom_range(0, KLS_MAX_KEYS - 1);
        lo_t = (i > 0) ? {32'd0, gen_time[i-1]} : 64'd0;
        hi_t = (i < KLS_MAX_KEYS - 1) ? {32'd0, gen_time[i+1]} : 64'hFFFF_FFFF;
        if (hi_t >= lo_t) begin
            lo_t = lo_t + ({32'd0, $urandom} % (hi_t - lo_t + 1));
        end else begin
            lo_t = {32'd0, $urandom};
        end
        push_load(i, 32'(lo_t), rand_comp(), rand_comp(), rand_comp(), rand_comp());
    endtask

    // queries aimed at key times, just either side of them, inside the spans, or random and extreme
    function automatic logic [KLS_TIME_W-1:0] pick_query(int n);
        int i;
        int j;
        logic [63:0] lo_t;
        logic [63:0] hi_t;
        if (n == 0) return $urandom;
        i = $urandom_range(0, n - 1);
        j = (i < n - 1) ? i + 1 : i;
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            2:       return gen_time[i];
            3:       return gen_time[i] - 1'b1;
            4:       return gen_time[i] + 1'b1;
            default: begin
                lo_t = gen_time[i];
                hi_t = gen_time[j];
                if (hi_t > lo_t) return 32'(lo_t + ({32'd0, $urandom} % (hi_t - lo_t)));
                return gen_time[i];
            end
        endcase
    endfunction

    // registers only move while the block is idle: nothing queued, nothing owed,
    // and room for a load still being absorbed
    task automatic wait_drained();
        @(posedge i_clk);
        while (pending.size() != 0 || in_if.valid || due_points.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [KLS_CFG_IDX_W-1:0] idx, logic [KLS_CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == KLS_REG_KEY_COUNT) begin
            trk_keys = data[KLS_CNT_W-1:0];
        end else if (idx == KLS_REG_FOUR_COMP) begin
            trk_four = data[0];
        end
    endtask

    // driver: holds a transaction until it is taken, then idles in random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            drv_busy = in_if.valid;
            if (in_if.valid && in_if.ready) begin
                track_item(drv_item);
                drv_busy = 1'b0;
            end
            if (!drv_busy) begin
                if (src_gap > 0 || pending.size() == 0) begin
                    if (src_gap > 0) src_gap--;
                    in_if.valid <= 1'b0;
                end else begin
                    drv_item = pending.pop_front();
                    in_if.valid      <= 1'b1;
                    in_if.func       <= drv_item.func;
                    in_if.key_index  <= drv_item.key_index;
                    in_if.key_time   <= drv_item.key_time;
                    in_if.val_x      <= drv_item.val[0];
                    in_if.val_y      <= drv_item.val[1];
                    in_if.val_z      <= drv_item.val[2];
                    in_if.val_w      <= drv_item.val[3];
                    in_if.query_time <= drv_item.query_time;
                    if (idle_on && $urandom_range(0, 3) == 0) src_gap = $urandom_range(1, 19);
                end
            end
        end
    end

    // monitor: checks each result transaction against the oldest owed point
    task automatic check_result();
        t_kf_point want;
        logic [KLS_VAL_W-1:0] got[KLS_COMP];
        got[0] = out_if.out_x;
        got[1] = out_if.out_y;
        got[2] = out_if.out_z;
        got[3] = out_if.out_w;
        result_cnt++;
        if (due_points.size() == 0) begin
            log_error($sformatf("result %0d with no sample outstanding", result_cnt));
            return;
        end
        want = due_points.pop_front();
        for (int c = 0; c < KLS_COMP; c++) begin
            if (got[c] !== want.comp[c]) begin
                log_error($sformatf("result %0d %s got %h want %h",
                                    result_cnt, comp_tag[c], got[c], want.comp[c]));
            end
        end
        if (out_if.empty_res !== want.empty) begin
            log_error($sformatf("result %0d empty_res got %b want %b",
                                result_cnt, out_if.empty_res, want.empty));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) check_result();
            if (snk_stall > 0) begin
                snk_stall--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0) snk_stall = $urandom_range(1, 19);
            end
        end
    end

    initial begin
        int phase;
        int span_len;
        int n_eff;
        int pick;
        logic [KLS_CNT_W-1:0] keys;
        logic four;

        // every input known from time zero
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_data       = '0;
        in_if.valid      = 1'b0;
        in_if.func       = KLS_FUNC_LOAD;
        in_if.key_index  = '0;
        in_if.key_time   = '0;
        in_if.val_x      = '0;
        in_if.val_y      = '0;
        in_if.val_z      = '0;
        in_if.val_w      = '0;
        in_if.query_time = '0;
        out_if.ready     = 1'b0;
        trk_keys         = '0;
        trk_four         = 1'b0;
        src_gap          = 0;
        snk_stall        = 0;
        idle_on          = 1'b1;
        queued           = 0;
        err_cnt          = 0;
        result_cnt       = 0;
        cycle_cnt        = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed part ---
        // empty table straight out of reset
        push_query(32'h0000_0000);
        push_query(32'hFFFF_FFFF);
        // four keys with full-scale swings, a repeated time and a last key at the top
        push_load(0, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        push_load(1, 32'h0003_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h0000_0001);
        push_load(2, 32'h0003_0000, 32'h1234_5678, 32'hFFFF_FFF0, 32'h8000_0000, 32'h7FFF_FFFF);
        push_load(3, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000);
        wait_drained();
        write_reg(KLS_REG_KEY_COUNT, 7'd4);
        write_reg(KLS_REG_FOUR_COMP, 7'd1);
        push_query(32'h0000_0000);      // before the first key: last key returned
        push_query(32'h0001_0000);      // exactly on the first key, zero fraction
        push_query(32'h0001_0001);      // one above the first key, fraction still rounds to zero
        push_query(32'h0002_0000);      // halfway
        push_query(32'h0002_FFFF);      // fraction close to one
        push_query(32'h0003_0000);      // on the repeated time, skips to the top span
        push_query(32'hFFFF_FFFE);      // widest span, fraction at its top
        push_query(32'hFFFF_FFFF);      // on the last key: no later key
        // load outside the keys in use, then rewrite an interior key and look again
        push_load(63, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001);
        push_load(1, 32'h0002_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000);
        push_query(32'h0001_8000);
        wait_drained();
        // three-component mode: w forced to zero
        write_reg(KLS_REG_FOUR_COMP, 7'd0);
        push_query(32'h0001_8000);
        push_query(32'h0000_0000);
        wait_drained();
        // a single key in use
        write_reg(KLS_REG_KEY_COUNT, 7'd1);
        push_query(32'h0000_0000);
        push_query(32'hFFFF_FFFF);

        // --- random part: one register setting per phase ---
        phase = 0;
        while (queued < ITEM_TARGET) begin
            wait_drained();
            case (phase)
                0: keys = 7'd64;
                1: keys = 7'd127;              // above the table size, saturates
                2: keys = 7'd1;
                default: begin
                    case ($urandom_range(0, 9))
                        0:       keys = 7'd0;
                        1:       keys = 7'd1;
                        2:       keys = 7'd2;
                        3:       keys = 7'd64;
                        4:       keys = 7'd127;
                        5:       keys = 7'($urandom_range(65, 126));
                        default: keys = 7'($urandom_range(3, 63));
                    endcase
                end
            endcase
            four = (phase == 0) ? 1'b1 : (phase == 1) ? 1'b0 : 1'($urandom_range(0, 1));
            write_reg(KLS_REG_KEY_COUNT, {{(KLS_CFG_DATA_W-KLS_CNT_W){1'b0}}, keys});
            write_reg(KLS_REG_FOUR_COMP, {{(KLS_CFG_DATA_W-1){1'b0}}, four});
            idle_on = (queued < CALM_FROM) && ($urandom_range(0, 3) != 0);

            n_eff = (keys > KLS_MAX_KEYS) ? KLS_MAX_KEYS : int'(keys);
            // the first phase fills the whole table, so no later read hits an unwritten entry
            if (phase == 0) begin
                push_sorted_keys(KLS_MAX_KEYS);
            end else if ($urandom_range(0, 2) == 0) begin
                push_sorted_keys((n_eff < 2) ? 2 : n_eff);
            end

            span_len = $urandom_range(40, 120);
            for (int k = 0; k < span_len; k++) begin
                pick = $urandom_range(0, 19);
                if (pick < 2) begin
                    push_repair_load();
                end else if (pick == 2) begin
                    // noise: any entry, any time, breaks the ordering
                    push_load($urandom_range(0, KLS_MAX_KEYS - 1), $urandom,
                              $urandom, $urandom, $urandom, $urandom);
                end else begin
                    push_query(pick_query(n_eff));
                end
            end
            phase++;
        end

        wait_drained();
        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- keyframe_lerp_sampler.f -----
rtl/core/kls_pkg.sv
rtl/core/kls_in_if.sv
rtl/core/kls_out_if.sv
rtl/core/kls_ram.sv
rtl/core/kls_ctrl.sv
rtl/core/kls_dp.sv
rtl/core/keyframe_lerp_sampler.sv
bench/keyframe_lerp_sampler_tb.sv
